/* rtl/src_pkg.sv */
// Package for the sensor rescale correction block.
// Holds event kinds, constants and the controller/datapath command types; no dependencies.
package src_pkg;

    localparam int LINK_COUNT_DEF = 4;

    localparam logic [11:0] NO_FACTOR = 12'd1000;
    localparam logic [9:0]  PM_SCALE  = 10'd1000;
    localparam logic [8:0]  PM_HALF   = 9'd500;
    localparam logic [13:0] CORR_MAX  = 14'd16383;

    localparam logic [1:0] REG_MIN_FACTOR     = 2'd0;
    localparam logic [1:0] REG_MAX_FACTOR     = 2'd1;
    localparam logic [1:0] REG_PENDING_WINDOW = 2'd2;

    localparam logic [2:0] KIND_READING  = 3'd0;
    localparam logic [2:0] KIND_BACKFILL = 3'd1;
    localparam logic [2:0] KIND_SET      = 3'd2;
    localparam logic [2:0] KIND_STOP     = 3'd3;
    localparam logic [2:0] KIND_TICK     = 3'd4;

    // Width of the factor quotient and its numerator.
    localparam int QUOT_W = 22;

    typedef struct packed {
        logic load;     // latch the input item
        logic div_go;   // start one division
        logic div_step; // one restoring division step
        logic update;   // commit state and form the result
    } src_cmd_t;

    typedef struct packed {
        logic need_div; // the latched item needs a factor computation
        logic div_last; // the division is on its last step
    } src_sts_t;

endpackage

/* rtl/src_ctrl.sv */
// Controller state machine for the sensor rescale correction block.
// Depends on src_pkg for the command and status types.
module src_ctrl
    import src_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  src_sts_t sts,
    output src_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.need_div)
                begin
                    cmd.div_go = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/src_datapath.sv */
// Datapath of the sensor rescale correction block: state, divider and result registers.
// Depends on src_pkg for constants and the command and status types.
module src_datapath
    import src_pkg::*;
#(
    parameter int LINK_COUNT = LINK_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  src_cmd_t    cmd,
    output src_sts_t    sts,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [2:0]  kind,
    input  logic [15:0] sensor,
    input  logic [1:0]  link,
    input  logic [31:0] event_time,
    input  logic [11:0] raw_value,
    input  logic [11:0] target_value,
    input  logic [31:0] mono_seconds,
    output logic [13:0] corrected_value,
    output logic [11:0] applied_factor,
    output logic        activated,
    output logic        tick_expired,
    output logic [11:0] view_factor,
    output logic [11:0] view_pending,
    output logic        view_rejected,
    output logic        view_expired,
    output logic        engaged,
    output logic [11:0] raw_on_link
);

    localparam int STEP_W = $clog2(QUOT_W + 1);
    localparam int LINK_IDX_W = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

    // Reciprocal of 1000 scaled by 2^34, rounded up; exact for 24-bit dividends.
    localparam logic [24:0] RECIP_1000 = 25'd17179870;

    // Configuration registers.
    logic [11:0] min_factor_reg;
    logic [11:0] max_factor_reg;
    logic [15:0] pending_window_reg;

    // Block state.
    logic [11:0] active_factor_reg;
    logic [15:0] active_sensor_reg;
    logic [31:0] active_from_reg;
    logic [11:0] pending_target_reg;
    logic [15:0] pending_sensor_reg;
    logic [31:0] pending_deadline_reg;
    logic        reject_flag_reg;
    logic [15:0] reject_sensor_reg;
    logic        expired_flag_reg;
    logic [15:0] expired_sensor_reg;
    logic [11:0] link_raw_reg [LINK_COUNT];

    // Latched item.
    logic [2:0]  kind_reg;
    logic [15:0] sid_reg;
    logic [1:0]  link_reg;
    logic [31:0] etime_reg;
    logic [11:0] raw_reg;
    logic [11:0] target_reg;
    logic [31:0] now_reg;

    // Divider.
    logic [QUOT_W-1:0] quot_reg;
    logic [11:0]       rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [11:0]       div_target;

    logic link_ok;
    logic pend_hit;
    logic pend_expire;
    assign link_ok = 32'(link_reg) < 32'(LINK_COUNT);
    assign pend_hit = (pending_target_reg != 12'd0) && (pending_sensor_reg == sid_reg);
    assign pend_expire = (pending_deadline_reg != 32'd0) && (now_reg > pending_deadline_reg);

    // Pick the activation operands; a reading uses the pending target.
    always_comb
    begin
        div_target = target_reg;
        sts.need_div = 1'b0;
        sts.div_last = (step_reg == STEP_W'(1));
        case (kind_reg)
            KIND_READING:
            begin
                div_target = pending_target_reg;
                sts.need_div = pend_hit && !pend_expire && (raw_reg != 12'd0);
            end
            KIND_SET:
            begin
                sts.need_div = (target_reg != 12'd0) && (raw_reg != 12'd0);
            end
            default:
            begin
                sts.need_div = 1'b0;
            end
        endcase
    end

    // Restoring division step: shift in one numerator bit a cycle.
    logic [12:0] rem_shift;
    logic [12:0] rem_sub;
    assign rem_shift = {rem_reg, quot_reg[QUOT_W-1]};
    assign rem_sub = rem_shift - {1'b0, raw_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_go)
        begin
            quot_reg <= QUOT_W'(div_target) * QUOT_W'(PM_SCALE) + QUOT_W'(raw_reg[11:1]);
            rem_reg <= 12'd0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[12])
            begin
                rem_reg <= rem_sub[11:0];
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[11:0];
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_go)
        begin
            step_reg <= STEP_W'(QUOT_W);
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // Latch the input item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            sid_reg <= sensor;
            link_reg <= link;
            etime_reg <= event_time;
            raw_reg <= raw_value;
            target_reg <= target_value;
            now_reg <= mono_seconds;
        end
    end

    // Next-state logic for one committed event.
    logic [11:0] af_n;
    logic [15:0] as_n;
    logic [31:0] afr_n;
    logic [11:0] pt_n;
    logic [15:0] ps_n;
    logic [31:0] pd_n;
    logic        rf_n;
    logic [15:0] rs_n;
    logic        ef_n;
    logic [15:0] es_n;
    logic        act_n;
    logic        texp_n;
    logic        do_act;
    logic        fac_ok;
    logic [11:0] pm_n;
    logic        fac_mine;
    logic        pend_mine;

    always_comb
    begin
        af_n = active_factor_reg;
        as_n = active_sensor_reg;
        afr_n = active_from_reg;
        pt_n = pending_target_reg;
        ps_n = pending_sensor_reg;
        pd_n = pending_deadline_reg;
        rf_n = reject_flag_reg;
        rs_n = reject_sensor_reg;
        ef_n = expired_flag_reg;
        es_n = expired_sensor_reg;
        act_n = 1'b0;
        texp_n = 1'b0;
        do_act = 1'b0;
        fac_ok = (quot_reg >= QUOT_W'(min_factor_reg))
            && (quot_reg <= QUOT_W'(max_factor_reg));
        case (kind_reg)
            KIND_READING:
            begin
                if (pend_hit)
                begin
                    if (pend_expire)
                    begin
                        ef_n = 1'b1;
                        es_n = sid_reg;
                    end
                    else
                    begin
                        act_n = 1'b1;
                        do_act = sts.need_div;
                    end
                    pt_n = 12'd0;
                    ps_n = 16'd0;
                    pd_n = 32'd0;
                end
            end
            KIND_SET:
            begin
                if (target_reg != 12'd0)
                begin
                    rf_n = 1'b0;
                    ef_n = 1'b0;
                    if (raw_reg != 12'd0)
                    begin
                        do_act = 1'b1;
                        pt_n = 12'd0;
                        ps_n = 16'd0;
                        pd_n = 32'd0;
                    end
                    else
                    begin
                        pt_n = target_reg;
                        ps_n = sid_reg;
                        pd_n = now_reg + 32'(pending_window_reg);
                    end
                end
            end
            KIND_STOP:
            begin
                af_n = NO_FACTOR;
                as_n = 16'd0;
                afr_n = 32'd0;
                pt_n = 12'd0;
                ps_n = 16'd0;
                pd_n = 32'd0;
                rf_n = 1'b0;
                ef_n = 1'b0;
            end
            KIND_TICK:
            begin
                if ((pending_target_reg != 12'd0) && pend_expire)
                begin
                    ef_n = 1'b1;
                    es_n = pending_sensor_reg;
                    pt_n = 12'd0;
                    ps_n = 16'd0;
                    pd_n = 32'd0;
                    texp_n = 1'b1;
                end
            end
            default:
            begin
                af_n = active_factor_reg;
            end
        endcase
        if (do_act)
        begin
            if (fac_ok)
            begin
                af_n = quot_reg[11:0];
                as_n = sid_reg;
                afr_n = etime_reg;
                rf_n = 1'b0;
            end
            else
            begin
                rf_n = 1'b1;
                rs_n = sid_reg;
            end
        end
        if ((af_n != NO_FACTOR) && (as_n == sid_reg) && (etime_reg >= afr_n))
        begin
            pm_n = af_n;
        end
        else
        begin
            pm_n = NO_FACTOR;
        end
        fac_mine = (af_n != NO_FACTOR) && (as_n == sid_reg);
        pend_mine = (pt_n != 12'd0) && (ps_n == sid_reg);
    end

    // Commit the state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_factor_reg <= 12'd750;
            max_factor_reg <= 12'd1250;
            pending_window_reg <= 16'd900;
            active_factor_reg <= NO_FACTOR;
            active_sensor_reg <= '0;
            active_from_reg <= '0;
            pending_target_reg <= '0;
            pending_sensor_reg <= '0;
            pending_deadline_reg <= '0;
            reject_flag_reg <= 1'b0;
            reject_sensor_reg <= '0;
            expired_flag_reg <= 1'b0;
            expired_sensor_reg <= '0;
            for (int i = 0; i < LINK_COUNT; i++)
            begin
                link_raw_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MIN_FACTOR:     min_factor_reg <= cfg_data[11:0];
                    REG_MAX_FACTOR:     max_factor_reg <= cfg_data[11:0];
                    REG_PENDING_WINDOW: pending_window_reg <= cfg_data;
                    default:            min_factor_reg <= min_factor_reg;
                endcase
            end
            if (cmd.update)
            begin
                active_factor_reg <= af_n;
                active_sensor_reg <= as_n;
                active_from_reg <= afr_n;
                pending_target_reg <= pt_n;
                pending_sensor_reg <= ps_n;
                pending_deadline_reg <= pd_n;
                reject_flag_reg <= rf_n;
                reject_sensor_reg <= rs_n;
                expired_flag_reg <= ef_n;
                expired_sensor_reg <= es_n;
                for (int i = 0; i < LINK_COUNT; i++)
                begin
                    if ((kind_reg == KIND_READING) && (32'(link_reg) == i))
                    begin
                        link_raw_reg[i] <= raw_reg;
                    end
                end
            end
        end
    end

    // Correction multiply, registered before the rounding divide by 1000.
    logic [23:0] prod_reg;
    logic        pass_reg;
    logic [11:0] raw_hold_reg;
    logic        is_data;
    assign is_data = (kind_reg == KIND_READING) || (kind_reg == KIND_BACKFILL);

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            prod_reg <= 24'(raw_reg) * 24'(pm_n) + 24'(PM_HALF);
            pass_reg <= (pm_n == NO_FACTOR);
            raw_hold_reg <= raw_reg;
            applied_factor <= is_data ? pm_n : NO_FACTOR;
            activated <= act_n;
            tick_expired <= texp_n;
            view_factor <= fac_mine ? af_n : NO_FACTOR;
            view_pending <= pend_mine ? pt_n : 12'd0;
            view_rejected <= rf_n && (rs_n == sid_reg);
            view_expired <= ef_n && (es_n == sid_reg);
            engaged <= fac_mine || pend_mine;
            raw_on_link <= link_ok
                ? ((kind_reg == KIND_READING) ? raw_reg : link_raw_reg[LINK_IDX_W'(link_reg)])
                : 12'd0;
        end
    end

    // Divide by 1000 through the reciprocal: floor(x * RECIP_1000 / 2^34) equals
    // floor(x / 1000) for every x below 2^24, so no correction step is needed.
    logic [48:0] recip;
    logic [14:0] quot_1000;
    assign recip = 49'(prod_reg) * 49'(RECIP_1000);
    assign quot_1000 = recip[48:34];

    always_comb
    begin
        if (!is_data)
        begin
            corrected_value = 14'd0;
        end
        else if (pass_reg)
        begin
            corrected_value = 14'(raw_hold_reg);
        end
        else if (quot_1000 > 15'(CORR_MAX))
        begin
            corrected_value = CORR_MAX;
        end
        else
        begin
            corrected_value = quot_1000[13:0];
        end
    end

endmodule

/* rtl/sensor_rescale_correction_core.sv */
// Top level of the sensor rescale correction block.
// Depends on src_pkg, src_ctrl and src_datapath.
// One item is handled at a time. After its input transfer, an item without a factor
// computation goes through the decide and update states to the output state; a set
// with nonzero target and raw values, or a reading with a nonzero raw value that
// activates a live pending target, also runs a restoring divider between decide and
// update, one quotient bit per cycle for a 22-bit quotient. The result stays on the
// output until transferred, and the next item is taken in the cycle after that.
module sensor_rescale_correction_core
    import src_pkg::*;
#(
    parameter int LINK_COUNT = LINK_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [15:0] sensor,
    input  logic [1:0]  link,
    input  logic [31:0] event_time,
    input  logic [11:0] raw_value,
    input  logic [11:0] target_value,
    input  logic [31:0] mono_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] corrected_value,
    output logic [11:0] applied_factor,
    output logic        activated,
    output logic        tick_expired,
    output logic [11:0] view_factor,
    output logic [11:0] view_pending,
    output logic        view_rejected,
    output logic        view_expired,
    output logic        engaged,
    output logic [11:0] raw_on_link
);

    src_cmd_t cmd;
    src_sts_t sts;

    assign cfg_ready = 1'b1;

    src_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    src_datapath #(
        .LINK_COUNT (LINK_COUNT)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (kind),
        .sensor          (sensor),
        .link            (link),
        .event_time      (event_time),
        .raw_value       (raw_value),
        .target_value    (target_value),
        .mono_seconds    (mono_seconds),
        .corrected_value (corrected_value),
        .applied_factor  (applied_factor),
        .activated       (activated),
        .tick_expired    (tick_expired),
        .view_factor     (view_factor),
        .view_pending    (view_pending),
        .view_rejected   (view_rejected),
        .view_expired    (view_expired),
        .engaged         (engaged),
        .raw_on_link     (raw_on_link)
    );

endmodule
